FILE: sv/elementwise_atan2_angle_assert.svh
// ---------------------------------------------------------------------------
// elementwise_atan2_angle_assert.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ELEMENTWISE_ATAN2_ANGLE_ASSERT_SVH
`define ELEMENTWISE_ATAN2_ANGLE_ASSERT_SVH

// check a property while out of reset
`define EAA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define EAA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/eaa_pkg.sv
// ---------------------------------------------------------------------------
// eaa_pkg
// Shared types, constants and the arctangent table of the atan2 pipeline.
// ---------------------------------------------------------------------------
package eaa_pkg;

  localparam int INPUT_WIDTH    = 16;
  localparam int ROTATION_STEPS = 16;
  localparam int GUARD_BITS     = 24;
  localparam int TABLE_SIZE     = 24;
  localparam int NUM_CELLS      = (ROTATION_STEPS > TABLE_SIZE) ? TABLE_SIZE : ROTATION_STEPS;
  localparam int STEP_W         = $clog2(TABLE_SIZE);

  localparam int ANGLE_W = 16;
  localparam int VEC_W   = INPUT_WIDTH + 2 + GUARD_BITS;
  localparam int Z_W     = 28;
  localparam int RND_W   = Z_W - 11;

  localparam logic signed [Z_W-1:0]     HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

  typedef struct packed {
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [Z_W-1:0]     z;
    logic                      spec;
    logic signed [ANGLE_W-1:0] spec_angle;
  } vec_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] e;
    case (idx)
      5'd0:    e = 28'sd13176795;
      5'd1:    e = 28'sd7778716;
      5'd2:    e = 28'sd4110060;
      5'd3:    e = 28'sd2086331;
      5'd4:    e = 28'sd1047214;
      5'd5:    e = 28'sd524117;
      5'd6:    e = 28'sd262123;
      5'd7:    e = 28'sd131069;
      5'd8:    e = 28'sd65536;
      5'd9:    e = 28'sd32768;
      5'd10:   e = 28'sd16384;
      5'd11:   e = 28'sd8192;
      5'd12:   e = 28'sd4096;
      5'd13:   e = 28'sd2048;
      5'd14:   e = 28'sd1024;
      5'd15:   e = 28'sd512;
      5'd16:   e = 28'sd256;
      5'd17:   e = 28'sd128;
      5'd18:   e = 28'sd64;
      5'd19:   e = 28'sd32;
      5'd20:   e = 28'sd16;
      5'd21:   e = 28'sd8;
      5'd22:   e = 28'sd4;
      5'd23:   e = 28'sd2;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: sv/elementwise_atan2_angle.sv
// Stages: input stage, the chain of micro-rotation cells, output register.
// Throughput: one request per cycle; the whole chain advances together and
// holds only while the output register has a result not yet taken.
// Reset (rst, synchronous) clears the valid bit of every stage.
// ---------------------------------------------------------------------------
// elementwise_atan2_angle
// Four-quadrant atan2 in Q13 through a chain of CORDIC vectoring cells.
// ---------------------------------------------------------------------------
module elementwise_atan2_angle
  import eaa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [2*INPUT_WIDTH-1:0] s_tdata,   // x_component, y_component
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [ANGLE_W-1:0]       m_tdata    // angle
);

  logic                      advance;
  logic                      valid [NUM_CELLS+1];
  vec_t                      vec   [NUM_CELLS+1];
  logic signed [ANGLE_W-1:0] angle;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign m_tdata  = angle;

  eaa_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .in_valid    (s_tvalid),
    .x_component (s_tdata[INPUT_WIDTH-1:0]),
    .y_component (s_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH]),
    .out_valid   (valid[0]),
    .out_vec     (vec[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    eaa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .step      (STEP_W'(k)),
      .in_valid  (valid[k]),
      .in_vec    (vec[k]),
      .out_valid (valid[k+1]),
      .out_vec   (vec[k+1])
    );
  end

  eaa_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (valid[NUM_CELLS]),
    .in_vec    (vec[NUM_CELLS]),
    .out_valid (m_tvalid),
    .angle     (angle)
  );

endmodule

FILE: sv/eaa_prep.sv
// ---------------------------------------------------------------------------
// eaa_prep
// Input stage: quadrant fold, special cases and guard-bit scaling.
// ---------------------------------------------------------------------------
module eaa_prep
  import eaa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [INPUT_WIDTH-1:0] x_component,
  input  logic signed [INPUT_WIDTH-1:0] y_component,
  output logic                          out_valid,
  output vec_t                          out_vec
);

  localparam int EXT_W = INPUT_WIDTH + 2;

  logic signed [EXT_W-1:0] xe;
  logic signed [EXT_W-1:0] ye;
  logic signed [EXT_W-1:0] xr;
  logic signed [EXT_W-1:0] yr;
  vec_t                    vec_next;

  always_comb begin
    xe = EXT_W'(x_component);
    ye = EXT_W'(y_component);
    xr = xe;
    yr = ye;
    vec_next.z = '0;
    if (xe < 0) begin
      if (ye > 0) begin
        xr = ye;
        yr = -xe;
        vec_next.z = HALF_PI_Q24;
      end else begin
        xr = -ye;
        yr = xe;
        vec_next.z = -HALF_PI_Q24;
      end
    end
    vec_next.x = {xr, {GUARD_BITS{1'b0}}};
    vec_next.y = {yr, {GUARD_BITS{1'b0}}};
    vec_next.spec = (ye == 0) || (xe == 0);
    if (ye == 0) begin
      vec_next.spec_angle = (xe < 0) ? PI_Q13 : '0;
    end else begin
      vec_next.spec_angle = (ye > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

FILE: sv/eaa_cell.sv
// ---------------------------------------------------------------------------
// eaa_cell
// One CORDIC micro-rotation in vectoring mode, registered.
// ---------------------------------------------------------------------------
module eaa_cell
  import eaa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  logic              in_valid,
  input  vec_t              in_vec,
  output logic              out_valid,
  output vec_t              out_vec
);

  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  logic signed [Z_W-1:0]   e;
  vec_t                    vec_next;

  always_comb begin
    xs = in_vec.x >>> step;
    ys = in_vec.y >>> step;
    e  = atan_entry(step);
    vec_next = in_vec;
    if (!in_vec.y[VEC_W-1]) begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + e;
    end else begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule

FILE: sv/eaa_post.sv
// ---------------------------------------------------------------------------
// eaa_post
// Output stage: round Q24 to Q13, saturate, apply special cases.
// ---------------------------------------------------------------------------
module eaa_post
  import eaa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  vec_t                      in_vec,
  output logic                      out_valid,
  output logic signed [ANGLE_W-1:0] angle
);

  logic signed [Z_W-1:0]     zr;
  logic signed [RND_W-1:0]   r;
  logic signed [ANGLE_W-1:0] angle_next;

  always_comb begin
    zr = in_vec.z + Z_W'(1024);
    r  = RND_W'(zr >>> 11);
    if (r > RND_W'(PI_Q13)) begin
      angle_next = PI_Q13;
    end else if (r < -RND_W'(PI_Q13)) begin
      angle_next = -PI_Q13;
    end else begin
      angle_next = ANGLE_W'(r);
    end
    if (in_vec.spec) begin
      angle_next = in_vec.spec_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

FILE: sv/eaa_checker.sv
// ---------------------------------------------------------------------------
// eaa_checker
// Port-level checks of the atan2 pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`include "elementwise_atan2_angle_assert.svh"

module eaa_checker
  import eaa_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [ANGLE_W-1:0]       m_tdata
);

  `EAA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
  `EAA_ASSERT(a_range, m_tvalid |-> ($signed(m_tdata) <= PI_Q13) && ($signed(m_tdata) >= -PI_Q13), "angle out of range")
  `EAA_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
  `EAA_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid, "result present after reset")

endmodule

bind elementwise_atan2_angle eaa_checker u_eaa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of the CORDIC atan2 pipeline. A directed set of corner
// pairs (axes, extremes, the four quadrants, angles close to plus and minus
// pi) is followed by random pairs shaped toward axes, diagonals and the
// negative x axis. Every angle that leaves the block is compared in order
// with a listed or a fixed-point CORDIC angle, under random bursts on the
// input, random stalls on the output and one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import eaa_pkg::*;

  localparam int  NUM_DIRECTED  = 24;
  localparam int  NUM_RANDOM    = 1200;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  DRAIN_CYCLES  = NUM_CELLS + 20;
  localparam int  HOLD_AFTER    = 400;
  localparam int  LONG_HOLD     = 300;
  localparam int  PRINT_LIMIT   = 30;
  localparam int  TURN_STEPS    = (ROTATION_STEPS > TABLE_SIZE) ? TABLE_SIZE : ROTATION_STEPS;
  localparam longint QUARTER_TURN_Q24 = 64'sd26353589;

  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam int EDGE_VALUES [6] = '{-32768, -32767, -1, 0, 1, 32767};

  typedef struct packed {
    int x;
    int y;
    bit known;
    int angle;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{0, 0, 1'b1, 0},
    '{1, 0, 1'b1, 0},
    '{32767, 0, 1'b1, 0},
    '{-1, 0, 1'b1, 25736},
    '{-32768, 0, 1'b1, 25736},
    '{0, 1, 1'b1, 12868},
    '{0, 32767, 1'b1, 12868},
    '{0, -1, 1'b1, -12868},
    '{0, -32768, 1'b1, -12868},
    '{32767, 32767, 1'b0, 0},
    '{-32768, -32768, 1'b0, 0},
    '{-32768, 32767, 1'b0, 0},
    '{32767, -32768, 1'b0, 0},
    '{1, 1, 1'b0, 0},
    '{-1, 1, 1'b0, 0},
    '{-1, -1, 1'b0, 0},
    '{1, -1, 1'b0, 0},
    '{-32768, 1, 1'b0, 0},
    '{-32768, -1, 1'b0, 0},
    '{1, 32767, 1'b0, 0},
    '{1, -32768, 1'b0, 0},
    '{-32767, 32767, 1'b0, 0},
    '{12345, -6789, 1'b0, 0},
    '{-300, 4000, 1'b0, 0}
  };

  typedef struct {
    logic signed [INPUT_WIDTH-1:0] x;
    logic signed [INPUT_WIDTH-1:0] y;
    logic signed [ANGLE_W-1:0]     angle;
  } angle_entry_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [2*INPUT_WIDTH-1:0] s_tdata = '0;     // x_component, y_component
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [ANGLE_W-1:0]       m_tdata;          // angle

  logic               offer_known = 1'b0;
  logic [ANGLE_W-1:0] offer_angle = '0;

  angle_entry_t pending_angles [$];
  int accepted_requests = 0;
  int checked_angles    = 0;
  int mismatch_count    = 0;
  int cycle_count       = 0;
  int idle_cycles       = 0;
  int held_cycles       = 0;
  int burst_left        = 0;

  elementwise_atan2_angle dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [ANGLE_W-1:0] cordic_atan2_q13(
    input logic signed [INPUT_WIDTH-1:0] x_in,
    input logic signed [INPUT_WIDTH-1:0] y_in
  );
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint t;
    longint r;
    x = x_in;
    y = y_in;
    z = 0;
    if (y == 0) return (x < 0) ? PI_Q13 : '0;
    if (x == 0) return (y > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN_Q24;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN_Q24;
      end
    end
    x = x <<< GUARD_BITS;
    y = y <<< GUARD_BITS;
    for (int i = 0; i < TURN_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q24[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q24[i];
      end
    end
    r = (z + 64'sd1024) >>> 11;
    if (r > longint'(PI_Q13)) r = PI_Q13;
    if (r < -longint'(PI_Q13)) r = -longint'(PI_Q13);
    return r[ANGLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("[%0d] mismatch: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // hold each request until taken, then idle between bursts
  task automatic offer_request(
    input logic signed [INPUT_WIDTH-1:0] x,
    input logic signed [INPUT_WIDTH-1:0] y,
    input bit                            known,
    input logic signed [ANGLE_W-1:0]     angle
  );
    int gap;
    s_tvalid    <= 1'b1;
    s_tdata     <= {y, x};
    offer_known <= known;
    offer_angle <= angle;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      idle_cycles += gap;
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
  endtask

  always @(posedge clk) begin : angle_monitor
    angle_entry_t entry;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d angles outstanding", cycle_count,
               pending_angles.size());
      $display("status: fail");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        entry.x = s_tdata[INPUT_WIDTH-1:0];
        entry.y = s_tdata[2*INPUT_WIDTH-1:INPUT_WIDTH];
        entry.angle = offer_known ? offer_angle : cordic_atan2_q13(entry.x, entry.y);
        pending_angles.insert(pending_angles.size(), entry);
        accepted_requests <= accepted_requests + 1;
      end
      if (m_tvalid && m_tready) begin
        if (pending_angles.size() == 0) begin
          report_mismatch($sformatf("unexpected angle %0d", $signed(m_tdata)));
        end else begin
          entry = pending_angles.pop_front();
          checked_angles++;
          if (m_tdata !== entry.angle)
            report_mismatch($sformatf("angle for x=%0d y=%0d: got %0d expected %0d",
                                      entry.x, entry.y, $signed(m_tdata), entry.angle));
        end
      end
    end
  end

  // stall on a changing pattern, with one long hold-off once traffic is flowing
  initial begin : receiver
    int mode;
    int phase_left;
    int hold_left;
    int tick;
    bit hold_done;
    mode = 0;
    phase_left = 0;
    hold_left = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_requests >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        held_cycles++;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (tick % 5) != 4;
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic signed [INPUT_WIDTH-1:0] rx;
    logic signed [INPUT_WIDTH-1:0] ry;
    int mag;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    burst_left = $urandom_range(1, 48);

    foreach (DIRECTED_ROWS[i])
      offer_request(INPUT_WIDTH'(DIRECTED_ROWS[i].x), INPUT_WIDTH'(DIRECTED_ROWS[i].y),
                    DIRECTED_ROWS[i].known, ANGLE_W'(DIRECTED_ROWS[i].angle));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      rx = INPUT_WIDTH'($urandom);
      ry = INPUT_WIDTH'($urandom);
      case ($urandom_range(0, 9))
        5: begin
          rx = INPUT_WIDTH'($signed($urandom_range(0, 510)) - 255);
          ry = INPUT_WIDTH'($signed($urandom_range(0, 510)) - 255);
        end
        6: begin
          if ($urandom_range(0, 1)) rx = '0;
          else ry = '0;
        end
        7: begin
          rx = INPUT_WIDTH'(EDGE_VALUES[$urandom_range(0, 5)]);
          ry = INPUT_WIDTH'(EDGE_VALUES[$urandom_range(0, 5)]);
        end
        8: begin
          rx = INPUT_WIDTH'(-$signed($urandom_range(1, 32768)));
          ry = INPUT_WIDTH'($signed($urandom_range(0, 6)) - 3);
        end
        9: begin
          mag = $urandom_range(1, 32767);
          rx = INPUT_WIDTH'($urandom_range(0, 1) ? mag : -mag);
          ry = INPUT_WIDTH'($urandom_range(0, 1) ? mag : -mag);
        end
        default: ;
      endcase
      offer_request(rx, ry, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    do @(negedge clk); while (pending_angles.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d corner pairs, %0d random), %0d angles checked",
             accepted_requests, NUM_DIRECTED, NUM_RANDOM, checked_angles);
    $display("sender idled %0d cycles, receiver held off %0d cycles, %0d mismatches",
             idle_cycles, held_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
